[sv/rrcq_pkg.sv]
// Shared types and codes for the round-robin client queue block.
// No dependencies; every other file but rrcq_fifo imports this package.
package rrcq_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Item kind after classification by the front end
    typedef logic [1:0] t_kind;
    localparam t_kind K_ENQ  = 2'd0;
    localparam t_kind K_NEXT = 2'd1;
    localparam t_kind K_BAD  = 2'd2;

    // Port field widths
    localparam int CFG_W        = 4;
    localparam int CLIENT_W     = 6;
    localparam int HANDLE_W     = 32;
    localparam int STATUS_W     = 2;
    localparam int SRV_CLIENT_W = 3;
    localparam int PEND_W       = 8;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SRV_CLIENT_W-1:0] client;
        logic [HANDLE_W-1:0]     request;
        logic [PEND_W-1:0]       pending;
    } t_result;

endpackage

[sv/rrcq_front.sv]
// Front end: accepts input items, classifies them and holds one item.
// Depends on rrcq_pkg.
module rrcq_front #(
    parameter int CW   = 3,
    parameter int SW   = 32,
    parameter int CMPW = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic [rrcq_pkg::CLIENT_W-1:0]   i_client_num,
    input  logic [rrcq_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [CMPW-1:0]                 i_n_eff,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2+CW+SW-1:0]              o_item
);
    import rrcq_pkg::*;

    logic              r_valid;
    logic [2+CW+SW-1:0] r_item;
    t_kind             kind;

    // A next item needs no check; an enqueue outside the rotation is marked bad.
    always_comb begin
        if (i_cmd) begin
            kind = K_NEXT;
        end else if (CMPW'(i_client_num) >= i_n_eff) begin
            kind = K_BAD;
        end else begin
            kind = K_ENQ;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= {SW'(i_handle), CW'(i_client_num), kind};
        end
    end

endmodule

[sv/rrcq_fifo.sv]
// Two-entry queue between the front end and the back end.
// No package dependency; the item width comes in as a parameter.
module rrcq_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/rrcq_back.sv]
// Back end: per-client queues in one memory, round-robin pick, result register.
// Depends on rrcq_pkg.
module rrcq_back #(
    parameter int MC   = 8,
    parameter int QD   = 16,
    parameter int CW   = 3,
    parameter int SW   = 32,
    parameter int CMPW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  logic [2+CW+SW-1:0]   i_item,
    input  logic [CMPW-1:0]      i_n_eff,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rrcq_pkg::t_result    o_result
);
    import rrcq_pkg::*;

    localparam int HW    = (QD > 1) ? $clog2(QD) : 1;
    localparam int LW    = $clog2(QD + 1);
    localparam int TW    = $clog2(MC * QD + 1);
    localparam int EW    = (TW > PEND_W) ? TW : PEND_W;
    localparam int AW    = $clog2(MC * QD);
    localparam int DEPTH = MC * QD;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NORM = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [HW-1:0] r_head [MC];
    logic [LW-1:0] r_len  [MC];
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] r_start;
    logic [TW-1:0] r_total, n_total;
    logic [CW-1:0] r_pick;
    logic          r_out_valid;
    t_result       r_out;
    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] r_rd_data;

    t_kind         item_kind;
    logic [CW-1:0] item_client;
    logic [SW-1:0] item_handle;
    logic          can_out;
    logic          out_load;
    logic [1:0]    out_status;
    logic          enq_do;
    logic          deq_do;
    logic          start_load;
    logic          start_sub;
    logic          search_go;
    logic [CW-1:0] start;
    logic          full;
    logic [LW:0]   slot_sum;
    logic [HW-1:0] slot;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          found;
    logic [CW-1:0] pick;
    logic [HW-1:0] head_inc;
    logic [CMPW-1:0] cursor_inc;
    logic [MC-1:0] ne_vec;
    logic [MC-1:0] hi_vec;
    logic          found_hi;
    logic          found_any;
    logic [CW-1:0] idx_hi;
    logic [CW-1:0] idx_any;

    assign item_kind   = i_item[1:0];
    assign item_client = i_item[2 +: CW];
    assign item_handle = i_item[2+CW +: SW];
    assign can_out     = !r_out_valid || i_ready;

    // Enqueue slot: head plus length, wrapped once
    assign full     = (r_len[item_client] == LW'(QD));
    assign slot_sum = (LW+1)'(r_head[item_client]) + (LW+1)'(r_len[item_client]);
    assign slot     = (slot_sum >= (LW+1)'(QD)) ? HW'(slot_sum - (LW+1)'(QD)) : HW'(slot_sum);
    assign wr_addr  = AW'(item_client) * AW'(QD) + AW'(slot);

    // Search start: the cursor, or its reduced copy while it is out of range
    assign start = (r_state == S_NORM) ? r_start : r_cursor;

    // Rotating find-first among active clients that hold work
    always_comb begin
        found_hi  = 1'b0;
        found_any = 1'b0;
        idx_hi    = '0;
        idx_any   = '0;
        for (int i = 0; i < MC; i++) begin
            ne_vec[i] = (r_len[i] != '0) && (CMPW'(i) < i_n_eff);
            hi_vec[i] = ne_vec[i] && (CW'(i) >= start);
        end
        for (int i = MC - 1; i >= 0; i--) begin
            if (hi_vec[i]) begin
                found_hi = 1'b1;
                idx_hi   = CW'(i);
            end
            if (ne_vec[i]) begin
                found_any = 1'b1;
                idx_any   = CW'(i);
            end
        end
    end

    assign found      = found_any;
    assign pick       = found_hi ? idx_hi : idx_any;
    assign head_inc   = ((HW+1)'(r_head[pick]) + (HW+1)'(1) >= (HW+1)'(QD)) ?
                        '0 : r_head[pick] + HW'(1);
    assign cursor_inc = CMPW'(pick) + CMPW'(1);
    assign rd_addr    = AW'(pick) * AW'(QD) + AW'(r_head[pick]);

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        out_load   = 1'b0;
        out_status = ST_OK;
        enq_do     = 1'b0;
        deq_do     = 1'b0;
        start_load = 1'b0;
        start_sub  = 1'b0;
        search_go  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && can_out) begin
                    o_pop = 1'b1;
                    case (item_kind)
                        K_ENQ: begin
                            out_load = 1'b1;
                            if (full) begin
                                out_status = ST_FULL;
                            end else begin
                                enq_do = 1'b1;
                            end
                        end
                        K_NEXT: begin
                            if (r_total == '0) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else if (CMPW'(r_cursor) >= i_n_eff) begin
                                start_load = 1'b1;
                                n_state    = S_NORM;
                            end else begin
                                search_go = 1'b1;
                            end
                        end
                        default: begin
                            out_load   = 1'b1;
                            out_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_NORM: begin
                // Reduce the copy into the rotation; the cursor holds until a serve
                if (CMPW'(r_start) >= i_n_eff) begin
                    start_sub = 1'b1;
                end else begin
                    search_go = 1'b1;
                end
            end
            S_READ: begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (search_go) begin
            if (found) begin
                deq_do  = 1'b1;
                n_state = S_READ;
            end else begin
                out_load   = 1'b1;
                out_status = ST_EMPTY;
                n_state    = S_IDLE;
            end
        end
    end

    always_comb begin
        n_total = r_total;
        if (enq_do) begin
            n_total = r_total + TW'(1);
        end else if (deq_do) begin
            n_total = r_total - TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MC; i++) begin
                r_head[i] <= '0;
                r_len[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (enq_do) begin
                r_len[item_client] <= r_len[item_client] + LW'(1);
            end
            if (deq_do) begin
                r_len[pick]  <= r_len[pick] - LW'(1);
                r_head[pick] <= head_inc;
                r_cursor     <= (cursor_inc >= i_n_eff) ? '0 : CW'(cursor_inc);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_load) begin
            r_start <= r_cursor;
        end else if (start_sub) begin
            r_start <= CW'(CMPW'(r_start) - i_n_eff);
        end
        if (deq_do) begin
            r_pick <= pick;
        end
        if (out_load) begin
            r_out.status  <= out_status;
            r_out.pending <= (EW'(n_total) > EW'(255)) ? 8'hFF : PEND_W'(n_total);
            if (r_state == S_READ) begin
                r_out.client  <= SRV_CLIENT_W'(r_pick);
                r_out.request <= HANDLE_W'(r_rd_data);
            end else begin
                r_out.client  <= '0;
                r_out.request <= '0;
            end
        end
    end

    // Handle store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (enq_do) begin
            mem[wr_addr] <= item_handle;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[sv/round_robin_client_queues.sv]
// Top level of the round-robin client queue block.
// Depends on rrcq_pkg, rrcq_front, rrcq_fifo and rrcq_back.
//
// Keeps one FIFO of request handles per client and serves the clients in
// round-robin order. An enqueue item (tuser 0) appends a handle to its
// client's queue, or reports bad client (outside the rotation) or queue full.
// A next item (tuser 1) pops the oldest handle of the first client with work
// at or after the turn cursor and moves the cursor past it; with no work it
// reports nothing pending. Every result carries the total pending count,
// saturated at 255. In the back end an enqueue, a dropped item or a next that
// serves nobody is finished in the idle state; a next that serves also passes
// the read state (search and issue the handle memory read, then take the
// registered read data). When active_clients was lowered below the turn
// cursor, a next with work pending first copies the cursor, then subtracts
// the rotation size from that copy until it is in range; the cursor itself
// holds until a client is served. The front register and the two-entry
// queue let input keep flowing while a result waits at the output. No
// clearing pass after reset: per-client lengths guard every read of the
// handle memory.
module round_robin_client_queues #(
    parameter int MAX_CLIENTS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrcq_pkg::CFG_W-1:0]         i_cfg_wdata,   // active_clients
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] client, [37:6] request_handle, [39:38] zero
    input  logic [rrcq_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,       // [0] cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] served_client, [34:3] served_request, [42:35] pending_count,
    // [47:43] zero
    output logic [rrcq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [rrcq_pkg::STATUS_W-1:0]      m_tuser        // [1:0] status
);
    import rrcq_pkg::*;

    localparam int CW   = $clog2(MAX_CLIENTS);
    localparam int SW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int NW   = $clog2(MAX_CLIENTS + 1);
    localparam int CMPW = (NW > CLIENT_W) ? NW : CLIENT_W;
    localparam int IW   = 2 + CW + SW;

    logic [CFG_W-1:0] r_active;
    logic [CMPW-1:0]  n_eff;
    logic             front_valid;
    logic             fifo_ready;
    logic [IW-1:0]    front_item;
    logic             fifo_valid;
    logic             back_pop;
    logic [IW-1:0]    fifo_item;
    t_result          result;

    // Hold the rotation size; it is to be written only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Clamp the register into 1..MAX_CLIENTS
    always_comb begin
        if (r_active == '0) begin
            n_eff = CMPW'(1);
        end else if (CMPW'(r_active) > CMPW'(MAX_CLIENTS)) begin
            n_eff = CMPW'(MAX_CLIENTS);
        end else begin
            n_eff = CMPW'(r_active);
        end
    end

    rrcq_front #(
        .CW   (CW),
        .SW   (SW),
        .CMPW (CMPW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_cmd        (s_tuser),
        .i_client_num (s_tdata[CLIENT_W-1:0]),
        .i_handle     (s_tdata[CLIENT_W +: HANDLE_W]),
        .i_n_eff      (n_eff),
        .o_valid      (front_valid),
        .i_ready      (fifo_ready),
        .o_item       (front_item)
    );

    rrcq_fifo #(
        .W (IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (fifo_ready),
        .i_data  (front_item),
        .o_valid (fifo_valid),
        .i_pop   (back_pop),
        .o_data  (fifo_item)
    );

    rrcq_back #(
        .MC   (MAX_CLIENTS),
        .QD   (QUEUE_DEPTH),
        .CW   (CW),
        .SW   (SW),
        .CMPW (CMPW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fifo_valid),
        .o_pop    (back_pop),
        .i_item   (fifo_item),
        .i_n_eff  (n_eff),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (result)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = {5'b0, result.pending, result.request, result.client};
    assign m_tuser = result.status;

endmodule

[sv/rrcq_checker.sv]
// Port-level checks for round_robin_client_queues, bound to the top level.
// Depends on rrcq_pkg and round_robin_client_queues.
module rrcq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [rrcq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [rrcq_pkg::STATUS_W-1:0]      m_tuser
);
    import rrcq_pkg::*;

    // No result survives a reset
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input side is open right after reset
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> s_tready)
        else $error("input not ready right after reset");

    // Served fields are zero unless the status is ok
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[34:0] == '0))
        else $error("served fields set on a failed item");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind round_robin_client_queues rrcq_checker u_rrcq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/round_robin_client_queues_tb.sv]
// Self-checking bench for round_robin_client_queues: a directed table, then random phases.
// Each phase has its own client count and idle pattern; every result is checked in order.
// Depends on rrcq_pkg and round_robin_client_queues.
`timescale 1ns / 1ps

module round_robin_client_queues_tb;
    import rrcq_pkg::*;

    localparam int NUM_CLIENTS     = 8;
    localparam int Q_DEPTH         = 16;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RX_HOLD_CYCLES  = 400;

    // Input command codes, carried on s_tuser
    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed sequence. A config row carries the register value
    // in the handle field. A typed row carries its expected result in want.
    typedef struct packed {
        t_row_kind        kind;
        logic             cmd;
        logic [5:0]       client;
        logic [31:0]      handle;
        logic [4:0]       reps;
        logic             typed;
        t_result          want;
    } t_row;

    localparam int DIR_ROWS = 25;
    localparam t_row DIR_TAB [DIR_ROWS] = '{
        // Empty after reset
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b1, '{ST_EMPTY, 3'd0, 32'h0, 8'd0}},
        // Client numbers outside the rotation
        '{ROW_ITEM, CMD_ENQ,  6'd63, 32'h12345678, 5'd1,  1'b1, '{ST_BAD, 3'd0, 32'h0, 8'd0}},
        '{ROW_ITEM, CMD_ENQ,  6'd8,  32'h87654321, 5'd1,  1'b1, '{ST_BAD, 3'd0, 32'h0, 8'd0}},
        // Extremes of client and handle
        '{ROW_ITEM, CMD_ENQ,  6'd0,  32'h0,        5'd1,  1'b1, '{ST_OK, 3'd0, 32'h0, 8'd1}},
        '{ROW_ITEM, CMD_ENQ,  6'd7,  32'hFFFFFFFF, 5'd1,  1'b1, '{ST_OK, 3'd0, 32'h0, 8'd2}},
        '{ROW_ITEM, CMD_ENQ,  6'd5,  32'hA5A5A5A5, 5'd1,  1'b1, '{ST_OK, 3'd0, 32'h0, 8'd3}},
        // Round-robin order from cursor 0
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b1, '{ST_OK, 3'd0, 32'h0, 8'd2}},
        '{ROW_ITEM, CMD_NEXT, 6'd63, 32'h0,        5'd1,  1'b1,
            '{ST_OK, 3'd5, 32'hA5A5A5A5, 8'd1}},
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b1,
            '{ST_OK, 3'd7, 32'hFFFFFFFF, 8'd0}},
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b1, '{ST_EMPTY, 3'd0, 32'h0, 8'd0}},
        // Fill client 3, then overflow it
        '{ROW_ITEM, CMD_ENQ,  6'd3,  32'h30000000, 5'd16, 1'b0, '0},
        '{ROW_ITEM, CMD_ENQ,  6'd3,  32'h3FFFFFFF, 5'd1,  1'b1, '{ST_FULL, 3'd0, 32'h0, 8'd16}},
        '{ROW_ITEM, CMD_ENQ,  6'd6,  32'h60000000, 5'd2,  1'b0, '0},
        // Serve 3 then 6, leaving the cursor at 7
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd2,  1'b0, '0},
        // Shrink to 4: cursor beyond count, client 6 stranded outside the rotation
        '{ROW_CFG,  CMD_ENQ,  6'd0,  32'd4,        5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b0, '0},
        '{ROW_ITEM, CMD_ENQ,  6'd5,  32'h55555555, 5'd1,  1'b0, '0},
        // Register value 0 acts as one client
        '{ROW_CFG,  CMD_ENQ,  6'd0,  32'd0,        5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_ENQ,  6'd1,  32'h11111111, 5'd1,  1'b0, '0},
        // Work pending outside the rotation only: nothing to serve
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b0, '0},
        '{ROW_ITEM, CMD_ENQ,  6'd0,  32'h00C0FFEE, 5'd1,  1'b0, '0},
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd1,  1'b0, '0},
        // Register value 15 acts as the full count; stranded clients rejoin
        '{ROW_CFG,  CMD_ENQ,  6'd0,  32'd15,       5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_NEXT, 6'd0,  32'h0,        5'd3,  1'b0, '0},
        '{ROW_CFG,  CMD_ENQ,  6'd0,  32'd8,        5'd0,  1'b0, '0}
    };

    localparam logic [CFG_W-1:0] PHASE_ACTIVE [PHASES] = '{
        4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd2, 4'd6, 4'd8
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = ACTIVE_RESET;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = CMD_ENQ;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // Idle pattern of the current phase, in percent of cycles
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    // Scheduler state mirrored by the bench
    logic [HANDLE_W-1:0] q_store [NUM_CLIENTS][Q_DEPTH];
    int unsigned         q_head [NUM_CLIENTS];
    int unsigned         q_len [NUM_CLIENTS];
    int unsigned         turn = 0;
    int unsigned         total_waiting = 0;
    logic [CFG_W-1:0]    active_setting = ACTIVE_RESET;

    t_result awaited_outcomes [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      nexts_sent = 0;
    int      cfg_writes = 0;
    int      status_seen [4] = '{0, 0, 0, 0};

    round_robin_client_queues u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Clients in rotation: 0 acts as 1, anything above the maximum as the maximum
    function automatic int unsigned rotation_size();
        if (active_setting == 0) return 1;
        if (active_setting > NUM_CLIENTS) return NUM_CLIENTS;
        return 32'(active_setting);
    endfunction

    // Apply one item to the mirrored queues and return the result it causes
    function automatic t_result queue_outcome(input logic cmd, input logic [5:0] client,
                                              input logic [HANDLE_W-1:0] handle);
        t_result     res;
        int unsigned n;
        int unsigned c;
        bit          served;
        res = '0;
        served = 1'b0;
        n = rotation_size();
        if (cmd == CMD_ENQ) begin
            if (client >= n) begin
                res.status = ST_BAD;
            end else if (q_len[client] >= Q_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                q_store[client][(q_head[client] + q_len[client]) % Q_DEPTH] = handle;
                q_len[client]++;
                total_waiting++;
                res.status = ST_OK;
            end
        end else begin
            res.status = ST_EMPTY;
            // Scan from the cursor, wrapped into the current rotation
            for (int k = 0; k < n && !served; k++) begin
                c = ((turn % n) + k) % n;
                if (q_len[c] != 0) begin
                    res.status = ST_OK;
                    res.client = c[SRV_CLIENT_W-1:0];
                    res.request = q_store[c][q_head[c]];
                    q_head[c] = (q_head[c] + 1) % Q_DEPTH;
                    q_len[c]--;
                    total_waiting--;
                    turn = (c + 1) % n;
                    served = 1'b1;
                end
            end
        end
        res.pending = (total_waiting > 255) ? 8'd255 : total_waiting[PEND_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Offer one item, idling first as the phase asks; return at the falling edge
    // after acceptance. Typed rows push their written-in result instead.
    task automatic offer_item(input logic cmd, input logic [5:0] client,
                              input logic [HANDLE_W-1:0] handle,
                              input logic typed, input t_result want);
        t_result res;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, handle, client};
        do @(posedge i_clk); while (!s_tready);
        res = queue_outcome(cmd, client, handle);
        awaited_outcomes.push_back(typed ? want : res);
        items_sent++;
        if (cmd == CMD_NEXT) nexts_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every result is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        active_setting = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: a long hold-off when asked, otherwise stall at the phase's rate
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            status_seen[m_tuser]++;
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected: status %0d data %h",
                                        m_tuser, m_tdata));
            end else begin
                want = awaited_outcomes.pop_front();
                if (m_tuser !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                if (m_tdata[2:0] !== want.client)
                    flag_mismatch($sformatf("served_client %0d, expected %0d",
                                            m_tdata[2:0], want.client));
                if (m_tdata[34:3] !== want.request)
                    flag_mismatch($sformatf("served_request %h, expected %h",
                                            m_tdata[34:3], want.request));
                if (m_tdata[42:35] !== want.pending)
                    flag_mismatch($sformatf("pending_count %0d, expected %0d",
                                            m_tdata[42:35], want.pending));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", awaited_outcomes.size());
        $display("round_robin_client_queues_tb NOT OK");
        $finish;
    end

    initial begin
        t_row        row;
        int unsigned n;
        int          enq_pct;
        int          hot_pct;
        int          pick;
        int unsigned hot;
        logic        cmd;
        logic [5:0]  client;

        for (int c = 0; c < NUM_CLIENTS; c++) begin
            q_head[c] = 0;
            q_len[c] = 0;
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: walk the table with no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TAB[r];
            if (row.kind == ROW_CFG) begin
                write_active(row.handle[CFG_W-1:0]);
            end else begin
                for (int k = 0; k < row.reps; k++)
                    offer_item(row.cmd, row.client, row.handle + k, row.typed, row.want);
            end
        end

        // Random part: each phase picks a client count, an idle pattern and a mix
        for (int ph = 0; ph < PHASES; ph++) begin
            write_active(PHASE_ACTIVE[ph]);
            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 72;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 72;
                end
                default: begin
                    tx_idle_pct = 33;
                    rx_stall_pct = 33;
                end
            endcase
            // Alternate filling and draining phases so queues hit both full and empty
            enq_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 35 : 60;
            hot_pct = (ph % 2 == 1) ? 50 : 0;
            hot = $urandom_range(NUM_CLIENTS - 1);
            // Hold the receiver off so the block backs up and stalls its input
            if (ph == 0) rx_hold_left = RX_HOLD_CYCLES;

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Pause the sender until every result is back
                if (ph == 5 && i == ITEMS_PER_PHASE / 2) drain();
                n = rotation_size();
                pick = $urandom_range(99);
                if ($urandom_range(99) < enq_pct) begin
                    cmd = CMD_ENQ;
                    if (pick < hot_pct)
                        client = 6'(hot % n);
                    else if (pick < 92)
                        client = 6'($urandom_range(n - 1));
                    else
                        client = 6'($urandom_range(63));
                end else begin
                    cmd = CMD_NEXT;
                    client = 6'($urandom_range(63));
                end
                offer_item(cmd, client, $urandom(), 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d items (%0d take-next) over %0d register writes.",
                 items_sent, nexts_sent, cfg_writes);
        $display("Results: ok %0d, bad client %0d, queue full %0d, nothing pending %0d.",
                 status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_FULL],
                 status_seen[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("round_robin_client_queues_tb OK");
        end else begin
            $display("round_robin_client_queues_tb NOT OK");
        end
        $finish;
    end

endmodule
